// ===== rtl/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared types, constants and the CRC-8 byte update for the scratchpad checker.
// ----------------------------------------------------------------------------
package tsc_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned AddrW   = 6;
  localparam int unsigned TempW   = 23;
  localparam int unsigned StatusW = 2;
  localparam int unsigned RawW    = 16;

  // Reflected form of polynomial 0x31
  localparam logic [ByteW-1:0] CRC_POLY_REFL = 8'h8C;
  // Position of the sensor's own CRC byte
  localparam logic [PosW-1:0]  LAST_POS      = 4'd8;
  // raw * 625 / 10 is raw * 125 / 2
  localparam int               TEMP_SCALE    = 125;
  localparam int               MK_OFFSET     = 273150;

  // Status bit positions
  localparam int unsigned ST_ADDR_BIT = 0;
  localparam int unsigned ST_CRC_BIT  = 1;

  // Frame data handed on when the CRC byte is processed
  typedef struct packed {
    logic                   valid;
    logic [ByteW-1:0]       crc_byte;
    logic [ByteW-1:0]       crc;
    logic [AddrW-1:0]       addr;
    logic signed [RawW-1:0] raw;
  } frame_end_t;

  // One byte of the reflected CRC-8, bit at a time
  function automatic logic [ByteW-1:0] crc8_update(input logic [ByteW-1:0] crc,
                                                   input logic [ByteW-1:0] b);
    logic [ByteW-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/tsc_if.sv =====
// ----------------------------------------------------------------------------
// Scratchpad checker channels
// Valid/ready channels for input bytes, results and the address register.
// ----------------------------------------------------------------------------
interface tsc_in_if import tsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] scratch_byte;
  logic             frame_restart;

  modport source (output valid, scratch_byte, frame_restart, input ready);
  modport sink   (input valid, scratch_byte, frame_restart, output ready);
endinterface

interface tsc_out_if import tsc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temperature_mk;
  logic [StatusW-1:0]      check_status;
  logic [AddrW-1:0]        seen_address;
  logic [ByteW-1:0]        computed_crc;

  modport source (output valid, temperature_mk, check_status, seen_address, computed_crc,
                  input ready);
  modport sink   (input valid, temperature_mk, check_status, seen_address, computed_crc,
                  output ready);
endinterface

interface tsc_cfg_if import tsc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] expected_addr;

  modport source (output valid, expected_addr, input ready);
  modport sink   (input valid, expected_addr, output ready);
endinterface

// ===== rtl/temp_scratchpad_checker.sv =====
// ----------------------------------------------------------------------------
// temp_scratchpad_checker
// Scratchpad checker for a 1-Wire temperature sensor: CRC-8, address check
// and conversion to millikelvin.
// ----------------------------------------------------------------------------
// Bytes arrive one per transfer on scratch, in scratchpad order 0 to 8; the
// block counts positions itself, and frame_restart marks a byte as byte 0 of
// a fresh read. One byte is taken every cycle unless the input stalls. Each
// byte passes an input register and a stage of logic (CRC-8 byte update or
// the final checks and a 16 x 7 bit scaling); result.valid rises once byte 8
// has gone from the input register into the output register, and the result
// then waits in the output register while new bytes keep coming.
// Only the CRC byte can stall the input, and only when the output register
// still holds an untaken result. The user must write the expected address
// through cfg only while no frame is in flight; the block does not enforce it.
module temp_scratchpad_checker import tsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tsc_in_if.sink    scratch,
  tsc_out_if.source result,
  tsc_cfg_if.sink   cfg
);

  logic [AddrW-1:0] expected_addr;
  frame_end_t       frame_end;
  logic             take;

  // Address register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_addr <= '0;
    end else if (cfg.valid) begin
      expected_addr <= cfg.expected_addr;
    end
  end

  tsc_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .scratch   (scratch),
    .take      (take),
    .frame_end (frame_end)
  );

  tsc_result u_result (
    .clk           (clk),
    .rst           (rst),
    .frame_end     (frame_end),
    .expected_addr (expected_addr),
    .take          (take),
    .result        (result)
  );

endmodule

// ===== rtl/tsc_frame.sv =====
// ----------------------------------------------------------------------------
// tsc_frame
// Input register plus frame tracking: byte position, running CRC and the
// temperature and address bytes of the current scratchpad.
// ----------------------------------------------------------------------------
module tsc_frame import tsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tsc_in_if.sink     scratch,
  input  logic       take,
  output frame_end_t frame_end
);

  // Input register
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_restart;

  // Frame state
  logic [PosW-1:0]  byte_position;
  logic [ByteW-1:0] running_crc;
  logic [ByteW-1:0] temp_low_byte;
  logic [ByteW-1:0] temp_high_byte;
  logic [AddrW-1:0] address_seen;

  logic [PosW-1:0]  pos;
  logic [ByteW-1:0] crc;
  logic             is_last;
  logic             advance;

  // Effective position and CRC of the registered byte
  always_comb begin
    pos     = s1_restart ? '0 : byte_position;
    crc     = s1_restart ? '0 : running_crc;
    is_last = (pos >= LAST_POS);
    // a CRC byte moves on only when the result register can take it
    advance = s1_valid && (!is_last || take);
  end

  assign scratch.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scratch.ready) begin
      s1_valid <= scratch.valid;
    end
    if (scratch.valid && scratch.ready) begin
      s1_byte    <= scratch.scratch_byte;
      s1_restart <= scratch.frame_restart;
    end
  end

  // Frame state update
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      running_crc    <= '0;
      temp_low_byte  <= '0;
      temp_high_byte <= '0;
      address_seen   <= '0;
    end else if (advance) begin
      if (!is_last) begin
        unique case (pos)
          PosW'(0): temp_low_byte  <= s1_byte;
          PosW'(1): temp_high_byte <= s1_byte;
          PosW'(2): address_seen   <= s1_byte[AddrW-1:0];
          default: ;
        endcase
        running_crc   <= crc8_update(crc, s1_byte);
        byte_position <= pos + PosW'(1);
      end else begin
        byte_position <= '0;
        running_crc   <= '0;
      end
    end
  end

  // Frame data towards the result stage
  always_comb begin
    frame_end.valid    = s1_valid && is_last;
    frame_end.crc_byte = s1_byte;
    frame_end.crc      = crc;
    frame_end.addr     = address_seen;
    frame_end.raw      = {temp_high_byte, temp_low_byte};
  end

endmodule

// ===== rtl/tsc_result.sv =====
// ----------------------------------------------------------------------------
// tsc_result
// Checks address and CRC, scales the raw reading to millikelvin and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module tsc_result import tsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  frame_end_t       frame_end,
  input  logic [AddrW-1:0] expected_addr,
  output logic             take,
  tsc_out_if.source        result
);

  localparam int unsigned ProdW = RawW + 8;

  logic                    out_valid;
  logic signed [TempW-1:0] out_temp;
  logic [StatusW-1:0]      out_status;
  logic [AddrW-1:0]        out_addr;
  logic [ByteW-1:0]        out_crc;

  logic [StatusW-1:0]      status;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] half;
  logic signed [ProdW-1:0] mk;

  assign take = !out_valid || result.ready;

  // Checks and temperature scaling
  always_comb begin
    status              = '0;
    status[ST_ADDR_BIT] = (frame_end.addr != expected_addr);
    status[ST_CRC_BIT]  = (frame_end.crc_byte != frame_end.crc);
    prod = ProdW'(frame_end.raw) * ProdW'(TEMP_SCALE);
    // halve with truncation toward zero
    half = (prod + $signed(ProdW'(prod[ProdW-1]))) >>> 1;
    mk   = half + ProdW'(MK_OFFSET);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= frame_end.valid;
    end
    if (frame_end.valid && take) begin
      out_temp   <= (status == '0) ? mk[TempW-1:0] : '0;
      out_status <= status;
      out_addr   <= frame_end.addr;
      out_crc    <= frame_end.crc;
    end
  end

  assign result.valid          = out_valid;
  assign result.temperature_mk = out_temp;
  assign result.check_status   = out_status;
  assign result.seen_address   = out_addr;
  assign result.computed_crc   = out_crc;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scratchpad checker testbench
// Streams scratchpad bytes into the checker and compares every result with a
// cycle-free model of the frame counter, CRC-8, address check and millikelvin
// conversion. A short table of directed bytes comes first, then phases of
// random frames and noise under different address settings, random idling on
// both sides, a long result hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb;
  import tsc_pkg::*;

  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;     // covers the two-stage pipeline with margin
  localparam int HOLD_CYCLES   = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam int NUM_PHASES    = 5;
  localparam int PHASE_ITEMS   = 165;
  localparam int IDLE_PCT      = 38;
  localparam int NUM_ROWS      = 29;

  // Scratchpad byte positions that carry data
  localparam logic [PosW-1:0] BYTE_TEMP_LO = 4'd0;
  localparam logic [PosW-1:0] BYTE_TEMP_HI = 4'd1;
  localparam logic [PosW-1:0] BYTE_STATUS  = 4'd2;

  // raw * 625 / 10, kept in tenths so truncation follows the signed divide
  localparam int MK_TENTHS = 625;
  localparam int MK_DIV    = 10;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ADDR = 2'd1,
    STATUS_CRC  = 2'd2,
    STATUS_BOTH = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp_mk;
    logic [StatusW-1:0]      status;
    logic [AddrW-1:0]        addr;
    logic [ByteW-1:0]        crc;
  } reading_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  // One directed step: a byte, or an address write when the block is idle
  typedef struct packed {
    row_kind_t        kind;
    logic [ByteW-1:0] data;
    logic             restart;
    logic             fill_crc;   // send the running CRC as the sensor's CRC byte
    logic             typed;      // use the reading below instead of the model
    reading_t         want;
  } stim_row_t;

  localparam reading_t NO_READING = '0;

  localparam stim_row_t DIRECTED [NUM_ROWS] = '{
    // all-zero frame straight after reset: address 0 matches, CRC is zero
    '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b1, '{23'sd273150, STATUS_OK, 6'd0, 8'h00}},
    '{ROW_CFG,  8'h3F, 1'b0, 1'b0, 1'b0, NO_READING},
    // stray byte, then a restart into the hottest reading with a good CRC
    '{ROW_BYTE, 8'h55, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h7F, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'hBF, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'hAA, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h5A, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'hC3, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b0, NO_READING},
    // zero frame against address 63 with a bad CRC byte: both checks fail
    '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, NO_READING},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 1'b1, '{23'sd0, STATUS_BOTH, 6'd0, 8'h00}}
  };

  logic clk;
  logic rst;

  tsc_in_if  scr ();
  tsc_out_if res ();
  tsc_cfg_if cfg_ch ();

  temp_scratchpad_checker dut (
    .clk    (clk),
    .rst    (rst),
    .scratch(scr),
    .result (res),
    .cfg    (cfg_ch)
  );

  // Model state of the frame being assembled
  logic [PosW-1:0]  frame_pos;
  logic [ByteW-1:0] crc_acc;
  logic [ByteW-1:0] temp_lo;
  logic [ByteW-1:0] temp_hi;
  logic [AddrW-1:0] addr_seen;
  logic [AddrW-1:0] dev_addr;

  reading_t pending_readings[$];
  int       mismatches;
  int       bytes_sent;
  int       hold_requests;
  int       holds_done;
  int       stall_cycles;
  bit       steady;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reflected CRC-8, one input bit at a time, LSB first
  function automatic logic [ByteW-1:0] crc8_step(input logic [ByteW-1:0] c,
                                                 input logic [ByteW-1:0] b);
    logic fb;
    for (int k = 0; k < ByteW; k++) begin
      fb = c[0] ^ b[k];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY_REFL;
    end
    return c;
  endfunction

  // Advances the frame model by one byte; returns 1 when a reading comes out
  function automatic bit predict_reading(input logic [ByteW-1:0] b, input logic restart,
                                         output reading_t r);
    logic [PosW-1:0]    p;
    logic [ByteW-1:0]   c;
    logic [StatusW-1:0] st;
    int                 mk;
    p = restart ? '0 : frame_pos;
    c = restart ? '0 : crc_acc;
    r = '0;
    if (p < LAST_POS) begin
      case (p)
        BYTE_TEMP_LO: temp_lo = b;
        BYTE_TEMP_HI: temp_hi = b;
        BYTE_STATUS:  addr_seen = b[AddrW-1:0];
        default: ;
      endcase
      crc_acc   = crc8_step(c, b);
      frame_pos = p + 1'b1;
      return 1'b0;
    end
    st = STATUS_OK;
    st[ST_ADDR_BIT] = (addr_seen != dev_addr);
    st[ST_CRC_BIT]  = (b != c);
    if (st == STATUS_OK) begin
      mk = (int'($signed({temp_hi, temp_lo})) * MK_TENTHS) / MK_DIV + MK_OFFSET;
      r.temp_mk = mk[TempW-1:0];
    end
    r.status  = st;
    r.addr    = addr_seen;
    r.crc     = c;
    frame_pos = '0;
    crc_acc   = '0;
    return 1'b1;
  endfunction

  // One byte transfer, with a random gap before it unless the phase is steady
  task automatic send_byte(input logic [ByteW-1:0] b, input logic restart,
                           input logic typed, input reading_t want);
    reading_t r;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        scr.valid <= 1'b0;
        @(posedge clk);
      end
    end
    scr.valid         <= 1'b1;
    scr.scratch_byte  <= b;
    scr.frame_restart <= restart;
    do @(posedge clk); while (scr.ready !== 1'b1);
    bytes_sent++;
    if (predict_reading(b, restart, r)) pending_readings.push_back(typed ? want : r);
  endtask

  // Stop offering bytes and let every reading and any trailing work drain out
  task automatic wait_drained();
    scr.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(input logic [AddrW-1:0] a);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.expected_addr <= a;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    dev_addr = a;
  endtask

  // Well-formed nine-byte read with random content, mostly matching checks
  task automatic send_frame();
    logic [RawW-1:0]  raw;
    logic [AddrW-1:0] a;
    logic [ByteW-1:0] last;
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(4))
        0: raw = 16'h7FFF;
        1: raw = 16'h8000;
        2: raw = 16'hFFFF;
        3: raw = 16'h0001;
        default: raw = 16'h0000;
      endcase
    end else begin
      raw = RawW'($urandom_range(16'hFFFF));
    end
    a = ($urandom_range(99) < 70) ? dev_addr : AddrW'($urandom_range(63));
    send_byte(raw[7:0], (frame_pos != 0) ? 1'b1 : 1'($urandom_range(1)), 1'b0, NO_READING);
    send_byte(raw[15:8], 1'b0, 1'b0, NO_READING);
    send_byte({2'($urandom_range(3)), a}, 1'b0, 1'b0, NO_READING);
    repeat (5) send_byte(8'($urandom_range(255)), 1'b0, 1'b0, NO_READING);
    last = ($urandom_range(99) < 75) ? crc_acc : 8'($urandom_range(255));
    send_byte(last, 1'b0, 1'b0, NO_READING);
  endtask

  // Broken sequence: a short run of random bytes with occasional restarts
  task automatic send_noise();
    repeat ($urandom_range(8, 1))
      send_byte(8'($urandom_range(255)), $urandom_range(4) == 0, 1'b0, NO_READING);
  endtask

  // Complete a partial frame so that the next address write sees a clean boundary
  task automatic finish_frame();
    while (frame_pos != 0) send_byte(8'($urandom_range(255)), 1'b0, 1'b0, NO_READING);
  endtask

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        res.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result transfer with the oldest pending reading
  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
      if (pending_readings.size() == 0) begin
        $error("result transfer with no reading pending");
        mismatches++;
      end else begin
        exp_r = pending_readings.pop_front();
        if (res.temperature_mk !== exp_r.temp_mk) begin
          $error("temperature_mk: expected %0d, got %0d", exp_r.temp_mk, res.temperature_mk);
          mismatches++;
        end
        if (res.check_status !== exp_r.status) begin
          $error("check_status: expected %0d, got %0d", exp_r.status, res.check_status);
          mismatches++;
        end
        if (res.seen_address !== exp_r.addr) begin
          $error("seen_address: expected %0d, got %0d", exp_r.addr, res.seen_address);
          mismatches++;
        end
        if (res.computed_crc !== exp_r.crc) begin
          $error("computed_crc: expected 0x%02h, got 0x%02h", exp_r.crc, res.computed_crc);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if ((scr.valid && scr.ready) || (res.valid && res.ready) || (cfg_ch.valid && cfg_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $error("no transfer for %0d cycles", stall_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int        phase_start;
    bit        paused;
    stim_row_t row;
    logic [AddrW-1:0] a;

    mismatches    = 0;
    bytes_sent    = 0;
    hold_requests = 0;
    holds_done    = 0;
    stall_cycles  = 0;
    steady        = 1'b0;
    frame_pos     = '0;
    crc_acc       = '0;
    temp_lo       = '0;
    temp_hi       = '0;
    addr_seen     = '0;
    dev_addr      = '0;

    rst                  <= 1'b1;
    scr.valid            <= 1'b0;
    scr.scratch_byte     <= '0;
    scr.frame_restart    <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.expected_addr <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_address(row.data[AddrW-1:0]);
      end else begin
        send_byte(row.fill_crc ? crc_acc : row.data, row.restart, row.typed, row.want);
      end
    end

    // Random phases, each under its own address setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: a = '0;
        1: a = '1;
        default: a = AddrW'($urandom_range(63));
      endcase
      write_address(a);
      // second phase runs flat out with one long result hold-off
      steady = (ph == 1);
      if (ph == 1) hold_requests++;
      phase_start = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - phase_start < PHASE_ITEMS) begin
        // third phase stops halfway until the block has emptied
        if (ph == 2 && !paused && bytes_sent - phase_start >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 85) send_frame();
        else send_noise();
      end
      finish_frame();
      steady = 1'b0;
    end

    scr.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tsc_pkg.sv
rtl/tsc_if.sv
rtl/tsc_frame.sv
rtl/tsc_result.sv
rtl/temp_scratchpad_checker.sv
tb/sv/tb.sv
